>>> rtl/core/chm_pkg.sv
package chm_pkg;

    // Command codes carried by an input item.
    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_FIND    = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    localparam int unsigned MIN_BUCKETS = 16;
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned KEY_W       = 32;

    typedef struct packed {
        logic [2:0]       command;
        logic [KEY_W-1:0] lookup_key;
        logic [KEY_W-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic             hit;
        logic [KEY_W-1:0] found_value;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    load_head;
        logic    step;
        logic    sel_free;
        logic    push;
        logic    set_found;
        logic    rep_write;
        logic    rem_unlink;
        logic    rem_free;
        logic    sweep;
        logic    load_out;
        t_status out_status;
        logic    out_hit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic cur_nil;
        logic steps_max;
        logic key_match;
        logic free_nil;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/chained_hash_map_engine_top.sv
// Chained hash map engine: a key-to-data map built from a bucket head memory
// and a node pool, with collisions resolved by separate chaining.
// The input channel (i_in_valid, o_in_stall, i_in_item) takes one command item
// at a time: insert, find, replace, remove or clear all. The output channel
// (o_out_valid, i_out_stall, o_out_item) returns exactly one result item per
// command, in order. The bucket count register sits at APB address zero.
// Find, insert, replace and remove items first wait on the serial remainder
// unit that picks their bucket (one key bit per cycle). Each chain node that
// a walk visits then takes a registered read of the node memories and a
// compare. Clear all sweeps the bucket head and link memories, and an unused
// command code goes straight to its result. The next item is taken in the
// cycle after its predecessor's result is loaded. After reset the same sweep
// runs once and the input stays stalled until it ends; configuration writes
// are taken at any time. The result waits in an output register while the
// receiver stalls; the next result then waits, with the input stalled, until
// that register is free.
module chained_hash_map_engine_top #(
    parameter int unsigned MAX_BUCKETS = 256,
    parameter int unsigned NODE_POOL   = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  chm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output chm_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    chm_pkg::t_dp_cmd              dp_cmd;
    chm_pkg::t_dp_sts              dp_sts;
    logic [chm_pkg::CFG_W-1:0]     r_bucket_count;

    // The only register is the bucket count; other addresses read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= chm_pkg::CFG_W'(chm_pkg::MIN_BUCKETS);
        end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
            r_bucket_count <= pwdata[chm_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(r_bucket_count) : 32'd0;

    chm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    chm_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .NODE_POOL   (NODE_POOL)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_in_item      (i_in_item),
        .i_bucket_count (r_bucket_count),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_item     (o_out_item)
    );

endmodule

>>> rtl/core/chm_div.sv
module chm_div #(
    parameter int unsigned DW = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    input  logic [DW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_rem
);

    // Restoring remainder, one key bit per cycle, most significant first.
    localparam int unsigned CW = $clog2(chm_pkg::KEY_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [chm_pkg::KEY_W-1:0] r_key;
    logic [DW-1:0]             r_div;
    logic [DW-1:0]             r_rem;
    logic [DW:0]               trial;
    logic [DW:0]               diff;

    assign trial = {r_rem, r_key[chm_pkg::KEY_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(chm_pkg::KEY_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_key <= {r_key[chm_pkg::KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[DW-1:0];
            end else begin
                r_rem <= trial[DW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/chm_dp.sv
module chm_dp #(
    parameter int unsigned MAX_BUCKETS = 256,
    parameter int unsigned NODE_POOL   = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chm_pkg::t_dp_cmd              i_cmd,
    output chm_pkg::t_dp_sts              o_sts,
    input  chm_pkg::t_in_item             i_in_item,
    input  logic [chm_pkg::CFG_W-1:0]     i_bucket_count,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output chm_pkg::t_out_item            o_out_item
);

    localparam int unsigned BW        = $clog2(MAX_BUCKETS);
    localparam int unsigned NW        = $clog2(NODE_POOL);
    localparam int unsigned LW        = $clog2(NODE_POOL + 1);
    localparam int unsigned MBW       = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned DW        = (MBW > chm_pkg::CFG_W) ? MBW : chm_pkg::CFG_W;
    localparam int unsigned SWEEP_LEN = (MAX_BUCKETS > NODE_POOL) ? MAX_BUCKETS : NODE_POOL;
    localparam int unsigned SWW       = $clog2(SWEEP_LEN);
    localparam logic [LW-1:0] NIL     = LW'(NODE_POOL);

    logic [LW-1:0]             heads [MAX_BUCKETS];
    logic [LW-1:0]             links [NODE_POOL];
    logic [chm_pkg::KEY_W-1:0] keys  [NODE_POOL];
    logic [chm_pkg::KEY_W-1:0] vals  [NODE_POOL];

    logic [chm_pkg::KEY_W-1:0] r_key;
    logic [chm_pkg::KEY_W-1:0] r_val;
    logic [chm_pkg::KEY_W-1:0] r_found;
    logic [LW-1:0]             r_cur;
    logic [LW-1:0]             r_prev;
    logic [LW-1:0]             r_free;
    logic [LW-1:0]             r_steps;
    logic [SWW-1:0]            r_sweep;
    logic                      r_out_valid;
    chm_pkg::t_out_item        r_out_item;

    logic [LW-1:0]             r_head_rd;
    logic [LW-1:0]             r_link_rd;
    logic [chm_pkg::KEY_W-1:0] r_key_rd;
    logic [chm_pkg::KEY_W-1:0] r_val_rd;

    logic [DW-1:0]             bc_ext;
    logic [DW-1:0]             divisor;
    logic                      div_done;
    logic [DW-1:0]             rem;
    logic [BW-1:0]             bucket;
    logic [NW-1:0]             node_addr;
    logic                      sweep_head;
    logic                      sweep_link;
    logic [LW-1:0]             sweep_next;

    // Bucket count in use, held between sixteen and the bucket array depth.
    assign bc_ext = DW'(i_bucket_count);
    always_comb begin
        if (bc_ext < DW'(chm_pkg::MIN_BUCKETS)) begin
            divisor = DW'(chm_pkg::MIN_BUCKETS);
        end else if (bc_ext > DW'(MAX_BUCKETS)) begin
            divisor = DW'(MAX_BUCKETS);
        end else begin
            divisor = bc_ext;
        end
    end

    chm_div #(.DW(DW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.accept),
        .i_key     (i_in_item.lookup_key),
        .i_divisor (divisor),
        .o_done    (div_done),
        .o_rem     (rem)
    );

    assign bucket     = rem[BW-1:0];
    assign node_addr  = i_cmd.sel_free ? r_free[NW-1:0] : r_cur[NW-1:0];
    assign sweep_head = ({1'b0, r_sweep} < (SWW+1)'(MAX_BUCKETS));
    assign sweep_link = ({1'b0, r_sweep} < (SWW+1)'(NODE_POOL));
    assign sweep_next = LW'({1'b0, r_sweep} + 1'b1);

    // Bucket head memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && sweep_head) begin
            heads[r_sweep[BW-1:0]] <= NIL;
        end else if (i_cmd.push) begin
            heads[bucket] <= r_free;
        end else if (i_cmd.rem_unlink && (r_prev == NIL)) begin
            heads[bucket] <= r_link_rd;
        end
        r_head_rd <= heads[bucket];
    end

    // Link memory, shared by the chains and the free list.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && sweep_link) begin
            links[r_sweep[NW-1:0]] <= sweep_next;
        end else if (i_cmd.push) begin
            links[r_free[NW-1:0]] <= r_head_rd;
        end else if (i_cmd.rem_unlink && (r_prev != NIL)) begin
            links[r_prev[NW-1:0]] <= r_link_rd;
        end else if (i_cmd.rem_free) begin
            links[r_cur[NW-1:0]] <= r_free;
        end
        r_link_rd <= links[node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            keys[r_free[NW-1:0]] <= r_key;
        end
        r_key_rd <= keys[node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            vals[r_free[NW-1:0]] <= r_val;
        end else if (i_cmd.rep_write) begin
            vals[r_cur[NW-1:0]] <= r_val;
        end
        r_val_rd <= vals[node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_free  <= '0;
                r_sweep <= (r_sweep == SWW'(SWEEP_LEN - 1)) ? '0 : r_sweep + 1'b1;
            end else if (i_cmd.push) begin
                r_free <= r_link_rd;
            end else if (i_cmd.rem_free) begin
                r_free <= r_cur;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key   <= i_in_item.lookup_key;
            r_val   <= i_in_item.entry_value;
            r_found <= '0;
        end else if (i_cmd.set_found) begin
            r_found <= r_val_rd;
        end
        if (i_cmd.load_head) begin
            r_cur   <= r_head_rd;
            r_prev  <= NIL;
            r_steps <= '0;
        end else if (i_cmd.step) begin
            r_cur   <= r_link_rd;
            r_prev  <= r_cur;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_item.status      <= i_cmd.out_status;
            r_out_item.hit         <= i_cmd.out_hit;
            r_out_item.found_value <= r_found;
        end
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.cur_nil    = (r_cur == NIL);
    assign o_sts.steps_max  = (r_steps == NIL);
    assign o_sts.key_match  = (r_key_rd == r_key);
    assign o_sts.free_nil   = (r_free == NIL);
    assign o_sts.sweep_last = (r_sweep == SWW'(SWEEP_LEN - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/core/chm_ctrl.sv
module chm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_command,
    output logic             o_in_stall,
    output chm_pkg::t_dp_cmd o_cmd,
    input  chm_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DIV, S_HEAD_RD, S_HEAD_LD, S_NODE_RD,
        S_NODE_CHK, S_REM_FREE, S_PUSH_RD, S_PUSH, S_DONE
    } t_state;

    t_state           r_state, n_state;
    chm_pkg::t_cmd    r_op, n_op;
    chm_pkg::t_status r_res, n_res;
    logic             r_hit, n_hit;
    logic             r_clear, n_clear;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_res   = r_res;
        n_hit   = r_hit;
        n_clear = r_clear;
        o_cmd   = '0;
        o_cmd.out_status = r_res;
        o_cmd.out_hit    = r_hit;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_clear ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_op    = chm_pkg::t_cmd'(i_command);
                    n_res   = chm_pkg::ST_DONE;
                    n_hit   = 1'b0;
                    n_clear = 1'b0;
                    case (i_command) inside
                        chm_pkg::CMD_INSERT, chm_pkg::CMD_FIND,
                        chm_pkg::CMD_REPLACE, chm_pkg::CMD_REMOVE: n_state = S_DIV;
                        chm_pkg::CMD_CLEAR: begin
                            n_clear = 1'b1;
                            n_state = S_SWEEP;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = (r_op == chm_pkg::CMD_INSERT) ? S_PUSH_RD : S_HEAD_RD;
                end
            end
            S_HEAD_RD: n_state = S_HEAD_LD;
            S_HEAD_LD: begin
                o_cmd.load_head = 1'b1;
                n_state = S_NODE_RD;
            end
            S_NODE_RD: begin
                if (i_sts.cur_nil || i_sts.steps_max) begin
                    if (r_op == chm_pkg::CMD_REPLACE) begin
                        n_state = S_PUSH_RD;
                    end else begin
                        n_res   = chm_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_NODE_CHK;
                end
            end
            S_NODE_CHK: begin
                if (i_sts.key_match) begin
                    n_hit = 1'b1;
                    if (r_op == chm_pkg::CMD_FIND) begin
                        o_cmd.set_found = 1'b1;
                        n_state = S_DONE;
                    end else if (r_op == chm_pkg::CMD_REPLACE) begin
                        o_cmd.rep_write = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rem_unlink = 1'b1;
                        n_state = S_REM_FREE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_NODE_RD;
                end
            end
            S_REM_FREE: begin
                o_cmd.rem_free = 1'b1;
                n_state = S_DONE;
            end
            S_PUSH_RD: begin
                o_cmd.sel_free = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.free_nil) begin
                    n_res = chm_pkg::ST_FULL;
                end else begin
                    o_cmd.push = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_op    <= chm_pkg::CMD_INSERT;
            r_res   <= chm_pkg::ST_DONE;
            r_hit   <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_res   <= n_res;
            r_hit   <= n_hit;
            r_clear <= n_clear;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/chm_checker.sv
module chm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input chm_pkg::t_out_item o_out_item
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One item at a time: an accepted item stalls the input next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // A hit always completes with done status.
    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit |-> o_out_item.status == chm_pkg::ST_DONE)
        else $error("hit with error status");

    // Data is only returned with a hit.
    a_found_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.found_value != '0) |-> o_out_item.hit)
        else $error("data returned without hit");

endmodule

bind chained_hash_map_engine_top chm_checker u_chm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> bench/tb_chained_hash_map_engine_top.sv
module tb_chained_hash_map_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_BUCKETS   = 256;
    localparam int unsigned N_NODES     = 256;
    localparam int unsigned NIL         = N_NODES;
    localparam int unsigned IDLE_LIMIT  = 200000;
    localparam logic [2:0]  ADDR_BUCKET_COUNT = 3'd0;
    // Command codes the block does not use; they must leave the map alone.
    localparam logic [2:0]  CMD_SPARE5 = 3'd5;
    localparam logic [2:0]  CMD_SPARE6 = 3'd6;
    localparam logic [2:0]  CMD_SPARE7 = 3'd7;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    chm_pkg::t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    chm_pkg::t_out_item o_out_item;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #1 i_clk = ~i_clk;

    chained_hash_map_engine_top u_top (.*);

    // Shadow copy of the map, kept in step with every accepted item.
    logic [8:0]  sh_heads [N_BUCKETS];
    logic [31:0] sh_keys  [N_NODES];
    logic [31:0] sh_vals  [N_NODES];
    logic [8:0]  sh_links [N_NODES];
    logic [8:0]  sh_free;
    logic [8:0]  sh_bucket_count;

    chm_pkg::t_out_item expected_results [$];
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;

    // Idling controls: the sender and receiver take random breaks when enabled.
    bit send_gaps = 1'b0;
    bit recv_gaps = 1'b0;
    bit recv_hold = 1'b0;
    int unsigned hold_cycles = 0;

    // Keys actually present, so that random finds and removes often hit.
    logic [31:0] live_keys [$];

    function automatic void map_reset_pool();
        for (int i = 0; i < N_BUCKETS; i++) sh_heads[i] = 9'(NIL);
        for (int i = 0; i < N_NODES; i++) sh_links[i] = 9'(i + 1);
        sh_free = '0;
    endfunction

    function automatic int unsigned buckets_now();
        int unsigned n;
        n = sh_bucket_count;
        if (n < chm_pkg::MIN_BUCKETS) n = chm_pkg::MIN_BUCKETS;
        if (n > N_BUCKETS) n = N_BUCKETS;
        return n;
    endfunction

    // Walks a chain for the first node carrying the key; prev is NIL at the head.
    function automatic int unsigned chain_search(int unsigned b, logic [31:0] key,
                                                 output int unsigned prev);
        int unsigned cur;
        int unsigned steps;
        cur = sh_heads[b];
        prev = NIL;
        steps = 0;
        while (cur < NIL && steps < N_NODES) begin
            if (sh_keys[cur] == key) return cur;
            prev = cur;
            cur = sh_links[cur];
            steps++;
        end
        prev = NIL;
        return NIL;
    endfunction

    function automatic bit chain_push(int unsigned b, logic [31:0] key, logic [31:0] val);
        int unsigned n;
        n = sh_free;
        if (n >= NIL) return 1'b0;
        sh_free = sh_links[n];
        sh_keys[n] = key;
        sh_vals[n] = val;
        sh_links[n] = sh_heads[b];
        sh_heads[b] = 9'(n);
        return 1'b1;
    endfunction

    function automatic chm_pkg::t_out_item predict_map_op(chm_pkg::t_in_item it);
        chm_pkg::t_out_item r;
        int unsigned b;
        int unsigned node;
        int unsigned prev;
        r = '0;
        r.status = chm_pkg::ST_DONE;
        b = it.lookup_key % buckets_now();
        case (it.command)
            chm_pkg::CMD_INSERT: begin
                if (!chain_push(b, it.lookup_key, it.entry_value))
                    r.status = chm_pkg::ST_FULL;
            end
            chm_pkg::CMD_FIND: begin
                node = chain_search(b, it.lookup_key, prev);
                if (node < NIL) begin
                    r.hit = 1'b1;
                    r.found_value = sh_vals[node];
                end else begin
                    r.status = chm_pkg::ST_NOT_FOUND;
                end
            end
            chm_pkg::CMD_REPLACE: begin
                node = chain_search(b, it.lookup_key, prev);
                if (node < NIL) begin
                    r.hit = 1'b1;
                    sh_vals[node] = it.entry_value;
                end else if (!chain_push(b, it.lookup_key, it.entry_value)) begin
                    r.status = chm_pkg::ST_FULL;
                end
            end
            chm_pkg::CMD_REMOVE: begin
                node = chain_search(b, it.lookup_key, prev);
                if (node < NIL) begin
                    r.hit = 1'b1;
                    if (prev < NIL) sh_links[prev] = sh_links[node];
                    else sh_heads[b] = sh_links[node];
                    sh_links[node] = sh_free;
                    sh_free = 9'(node);
                end else begin
                    r.status = chm_pkg::ST_NOT_FOUND;
                end
            end
            chm_pkg::CMD_CLEAR: map_reset_pool();
            default: ;
        endcase
        return r;
    endfunction

    // Offers one item at the next falling edge, taking a random break first when
    // the sender idles. Valid is dropped only by a break or by drain, so a new
    // item may follow at once while the block is still busy.
    task automatic send_item(logic [2:0] cmd, logic [31:0] key, logic [31:0] val);
        chm_pkg::t_in_item it;
        @(negedge i_clk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        it.command = cmd;
        it.lookup_key = key;
        it.entry_value = val;
        i_in_item <= it;
        i_in_valid <= 1'b1;
        // The prediction is made once the item is taken by the block.
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_map_op(it));
        items_sent++;
        if (cmd == chm_pkg::CMD_INSERT || cmd == chm_pkg::CMD_REPLACE) live_keys.push_back(key);
        if (cmd == chm_pkg::CMD_CLEAR) live_keys.delete();
    endtask

    // Waits until every expected result has come back, then lets the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_bucket_count(logic [8:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BUCKET_COUNT;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_bucket_count = value;
    endtask

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        chm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result item status=%0d", o_out_item.status);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out_item.status);
                    fail_count++;
                end
                if (o_out_item.hit !== want.hit) begin
                    $error("hit expected %0d actual %0d", want.hit, o_out_item.hit);
                    fail_count++;
                end
                if (o_out_item.found_value !== want.found_value) begin
                    $error("found_value expected %h actual %h",
                           want.found_value, o_out_item.found_value);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold when asked for.
    always @(negedge i_clk) begin
        if (recv_hold) begin
            i_out_stall <= 1'b1;
            if (hold_cycles != 0) hold_cycles--;
            else recv_hold = 1'b0;
        end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("chained_hash_map_engine_top verification failed");
            $finish;
        end
    end

    // Extremes of the key and data fields, every command and the odd codes.
    task automatic test_directed();
        send_item(chm_pkg::CMD_FIND, 32'h0, 32'h0);
        send_item(chm_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_item(chm_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_item(chm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_item(chm_pkg::CMD_FIND, 32'h0, 32'h0);
        send_item(chm_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A duplicate shadows the older node; removal uncovers it again.
        send_item(chm_pkg::CMD_INSERT, 32'h0, 32'h1234_5678);
        send_item(chm_pkg::CMD_FIND, 32'h0, 32'h0);
        send_item(chm_pkg::CMD_REMOVE, 32'h0, 32'h0);
        send_item(chm_pkg::CMD_FIND, 32'h0, 32'h0);
        // Same bucket, deeper in the chain.
        send_item(chm_pkg::CMD_INSERT, 32'd16, 32'hA5A5_A5A5);
        send_item(chm_pkg::CMD_INSERT, 32'd32, 32'h5A5A_5A5A);
        send_item(chm_pkg::CMD_REMOVE, 32'd16, 32'h0);
        send_item(chm_pkg::CMD_REPLACE, 32'd32, 32'hDEAD_BEEF);
        send_item(chm_pkg::CMD_REPLACE, 32'd48, 32'hCAFE_F00D);
        send_item(chm_pkg::CMD_FIND, 32'd32, 32'h0);
        send_item(chm_pkg::CMD_FIND, 32'd48, 32'h0);
        send_item(CMD_SPARE5, 32'd32, 32'h1);
        send_item(CMD_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_SPARE7, 32'd48, 32'h0);
        send_item(chm_pkg::CMD_FIND, 32'd32, 32'h0);
        send_item(chm_pkg::CMD_CLEAR, 32'd0, 32'd0);
        send_item(chm_pkg::CMD_FIND, 32'd32, 32'h0);
        drain();
    endtask

    // Fills the pool to the brim so that insert and replace report full.
    task automatic test_pool_full();
        for (int i = 0; i < N_NODES + 3; i++)
            send_item(chm_pkg::CMD_INSERT, 32'($urandom_range(0, 4095)), $urandom);
        send_item(chm_pkg::CMD_REPLACE, 32'hFFFF_0001, $urandom);
        send_item(chm_pkg::CMD_REMOVE, live_keys[0], 32'h0);
        send_item(chm_pkg::CMD_REPLACE, 32'hFFFF_0001, 32'h7777_7777);
        send_item(chm_pkg::CMD_FIND, 32'hFFFF_0001, 32'h0);
        send_item(chm_pkg::CMD_CLEAR, 32'd0, 32'd0);
        drain();
    endtask

    // Mostly lookups on live keys with random content; rest is noise.
    task automatic test_random_traffic(int unsigned count, bit narrow_keys);
        logic [31:0] key;
        logic [2:0]  cmd;
        for (int i = 0; i < count; i++) begin
            if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (narrow_keys)
                key = 32'($urandom_range(0, 1023));
            else
                key = $urandom;
            case ($urandom_range(0, 99)) inside
                [0:29]:  cmd = chm_pkg::CMD_INSERT;
                [30:54]: cmd = chm_pkg::CMD_FIND;
                [55:74]: cmd = chm_pkg::CMD_REPLACE;
                [75:95]: cmd = chm_pkg::CMD_REMOVE;
                [96:97]: cmd = chm_pkg::CMD_CLEAR;
                default: cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
            endcase
            send_item(cmd, key, $urandom);
        end
    endtask

    // Receiver holds off while items keep coming, filling the block up.
    task automatic test_backpressure();
        hold_cycles = 400;
        recv_hold = 1'b1;
        test_random_traffic(12, 1'b1);
        drain();
    endtask

    initial begin
        sh_bucket_count = 9'(chm_pkg::MIN_BUCKETS);
        map_reset_pool();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The post-reset sweep is covered by the input stall.
        test_directed();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_pool_full();
        // Bucket counts below the floor, at the floor, odd, at the top and above it.
        write_bucket_count(9'd0);
        test_random_traffic(80, 1'b1);
        drain();
        write_bucket_count(9'd37);
        test_random_traffic(100, 1'b1);
        drain();
        // Changing the count with entries in place strands some nodes.
        write_bucket_count(9'd256);
        test_random_traffic(100, 1'b0);
        drain();
        write_bucket_count(9'h1FF);
        test_random_traffic(60, 1'b1);
        drain();
        test_backpressure();
        write_bucket_count(9'd16);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random_traffic(60, 1'b1);
        drain();
        $display("Sent %0d items over bucket counts 0..511, pool exhaustion and back-pressure;",
                 items_sent);
        $display("checked %0d results, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("chained_hash_map_engine_top verification clean");
        else
            $display("chained_hash_map_engine_top verification failed");
        $finish;
    end
endmodule
